### rtl/vdsu_pkg.sv
// Package for the vector distance / score unit.
// Types, constants and saturation helpers shared by all rtl/ files.
`default_nettype none
package vdsu_pkg;

  localparam int SUM_W   = 44;
  localparam int RES_W   = 32;
  localparam int SHR_W   = 85;
  localparam int DEN_W   = 64;
  localparam int STEP_W  = 7;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [RES_W-1:0] ONE_Q20 = 32'sd1048576;

  localparam logic [1:0] METRIC_EUCLID = 2'd0;
  localparam logic [1:0] METRIC_COSINE = 2'd1;
  localparam logic [1:0] METRIC_DOT    = 2'd2;

  localparam logic REG_METRIC = 1'b0;
  localparam logic REG_SCORE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_PICK, S_SQE, S_DIVE, S_SQ1, S_SQ2, S_MUL, S_CMP, S_DIVC, S_FIN
  } state_t;

  typedef enum logic {OP_SQRT, OP_DIV} iter_op_t;

  typedef struct packed {
    logic                     start;
    iter_op_t                 op;
    logic [SHR_W-1:0]         operand;
    logic [DEN_W-1:0]         divisor;
    logic [STEP_W-1:0]        steps;
  } iter_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] dot;
    logic signed [SUM_W-1:0] norm_a;
    logic signed [SUM_W-1:0] norm_b;
    logic signed [SUM_W-1:0] diff;
  } sums_t;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] acc,
    input logic signed [33:0]      term
  );
    logic signed [SUM_W:0] s;
    s = {acc[SUM_W-1], acc} + (SUM_W+1)'(term);
    if (s > (SUM_W+1)'(SUM_MAX)) return SUM_MAX;
    else if (s < (SUM_W+1)'(SUM_MIN)) return SUM_MIN;
    else return s[SUM_W-1:0];
  endfunction

  function automatic logic signed [RES_W-1:0] sat_res(input logic signed [35:0] v);
    if (v > 36'sh07FFFFFFF) return 32'sh7FFFFFFF;
    else if (v < -36'sh080000000) return 32'sh80000000;
    else return v[RES_W-1:0];
  endfunction

endpackage
`default_nettype wire

### rtl/vector_distance_score_unit.sv
// Vector distance / score unit. Non-last beats are taken one per cycle.
// After the last beat, dot product and zero-norm cosine results need no root or
// divide; euclid and other cosine results wait on the shared root/divide unit
// (1 quotient bit per cycle when dividing), and a clamped cosine skips the divide;
// input is ready again once the result is in the output register.
// Synchronous reset clears sums, state, config registers and the output valid.
`default_nettype none
module vector_distance_score_unit import vdsu_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [31:0] s_axis_tdata,  // a_element[15:0], b_element[31:16]
  input  wire        s_axis_tlast,  // last_element
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [31:0] m_axis_tdata, // result_value[31:0]
  output logic       m_axis_tuser,  // zero_norm
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [1:0]  cfg_data
);

  state_t state, state_next;
  logic [1:0] metric_mode;
  logic       score_mode;
  sums_t      sums;
  iter_req_t  req;
  logic       it_busy, it_done;
  logic [31:0] it_quot;
  logic [31:0] sa;
  logic [63:0] den_r;
  logic signed [RES_W-1:0] res;
  logic       zero_r;
  logic       beat, clear, out_free;
  logic       use_cos, use_dot, norm_zero, dot_neg, big;
  logic signed [34:0] dq;
  logic signed [35:0] dqx;
  logic [43:0] tabs;
  logic [27:0] dv;
  logic [31:0] qr, qc;
  logic signed [RES_W-1:0] s_cos;

  assign beat          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign clear         = (state == S_FIN) && out_free;

  vdsu_accum u_accum (
    .clk, .rst, .beat_en(beat), .clear,
    .a_element(s_axis_tdata[15:0]), .b_element(s_axis_tdata[31:16]), .sums
  );

  vdsu_iter u_iter (
    .clk, .rst, .req, .busy(it_busy), .done(it_done), .quot(it_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= METRIC_EUCLID;
      score_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_METRIC: metric_mode <= cfg_data;
        REG_SCORE:  score_mode  <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    use_dot   = (metric_mode == METRIC_DOT);
    use_cos   = score_mode ? (metric_mode != METRIC_EUCLID && !use_dot)
                           : (metric_mode == METRIC_COSINE);
    norm_zero = (sums.norm_a <= 0) || (sums.norm_b <= 0);
    dot_neg   = sums.dot[SUM_W-1];
    dq        = 35'(({sums.dot[SUM_W-1], sums.dot} + 45'sd512) >>> 10);
    dqx       = {dq[34], dq};
    tabs      = dot_neg ? 44'(-sums.dot) : 44'(sums.dot);
    big       = tabs > den_r[63:20];
    dv        = 28'd1048576 + it_quot[27:0];
    qr        = (it_quot + 32'd1) >> 1;
    qc        = big ? 32'd1048576 : ((qr > 32'd1048576) ? 32'd1048576 : qr);
    s_cos     = dot_neg ? -$signed(qc) : $signed(qc);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (beat && s_axis_tlast) state_next = S_PICK;
      S_PICK: begin
        if (use_dot) state_next = S_FIN;
        else if (use_cos) state_next = norm_zero ? S_FIN : S_SQ1;
        else state_next = S_SQE;
      end
      S_SQE:  if (it_done) state_next = score_mode ? S_DIVE : S_FIN;
      S_DIVE: if (it_done) state_next = S_FIN;
      S_SQ1:  if (it_done) state_next = S_SQ2;
      S_SQ2:  if (it_done) state_next = S_MUL;
      S_MUL:  state_next = S_CMP;
      S_CMP:  state_next = big ? S_FIN : S_DIVC;
      S_DIVC: if (it_done) state_next = S_FIN;
      S_FIN:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    req.op = OP_SQRT;
    req.steps = 7'd32;
    unique case (state)
      S_PICK: begin
        req.start   = !use_dot && !(use_cos && norm_zero);
        req.operand = use_cos ? {1'b0, sums.norm_a[42:0], 20'd0, 21'd0}
                              : {11'd0, sums.diff[42:0], 10'd0, 21'd0};
      end
      S_SQ1: begin
        req.start   = it_done;
        req.operand = {1'b0, sums.norm_b[42:0], 20'd0, 21'd0};
      end
      S_SQE: begin
        req.start   = it_done && score_mode;
        req.op      = OP_DIV;
        req.steps   = 7'd41;
        req.operand = {41'h100_0000_0000 + 41'(dv >> 1), 44'd0};
        req.divisor = 64'(dv);
      end
      S_CMP: begin
        req.start   = !big;
        req.op      = OP_DIV;
        req.steps   = 7'd85;
        req.operand = {tabs, 41'd0};
        req.divisor = den_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_PICK: begin
        zero_r <= use_cos && norm_zero;
        if (use_dot) res <= score_mode ? sat_res(dqx) : sat_res(-dqx);
        else res <= score_mode ? 32'sd0 : ONE_Q20;
      end
      S_SQE:  if (it_done) res <= $signed(it_quot);
      S_DIVE: if (it_done) res <= $signed(it_quot);
      S_SQ1:  if (it_done) sa <= it_quot;
      S_MUL:  den_r <= sa * it_quot;
      S_CMP:  if (big) res <= score_mode ? s_cos : ONE_Q20 - s_cos;
      S_DIVC: if (it_done) res <= score_mode ? s_cos : ONE_Q20 - s_cos;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (clear) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      m_axis_tdata <= res;
      m_axis_tuser <= zero_r;
    end
  end

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0 || m_axis_tdata == 32'd1048576)
    else $error("zero-norm flag with a result other than 0 or 1.0");

  a_idle_unit: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !it_busy)
    else $error("input taken while root/divide unit busy");

  a_done_state: assert property (@(posedge clk) disable iff (rst)
    it_done |-> state == S_SQE || state == S_DIVE || state == S_SQ1 ||
                state == S_SQ2 || state == S_DIVC)
    else $error("root/divide finished outside a waiting state");

endmodule
`default_nettype wire

### rtl/vdsu_accum.sv
// Running sums: dot product, both squared norms, squared difference.
// Uses vdsu_pkg; saturating 44-bit accumulators in units of 2^-30.
`default_nettype none
module vdsu_accum import vdsu_pkg::*; (
  input  wire               clk,
  input  wire               rst,
  input  wire               beat_en,
  input  wire               clear,
  input  wire signed [15:0] a_element,
  input  wire signed [15:0] b_element,
  output sums_t             sums
);

  logic signed [31:0] p_ab, p_aa, p_bb;
  logic signed [16:0] d;
  logic signed [33:0] p_dd;

  always_comb begin
    p_ab = a_element * b_element;
    p_aa = a_element * a_element;
    p_bb = b_element * b_element;
    d    = 17'(a_element) - 17'(b_element);
    p_dd = d * d;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sums <= '0;
    end else if (beat_en) begin
      sums.dot    <= sat_add(sums.dot, 34'(p_ab));
      sums.norm_a <= sat_add(sums.norm_a, 34'(p_aa));
      sums.norm_b <= sat_add(sums.norm_b, 34'(p_bb));
      sums.diff   <= sat_add(sums.diff, p_dd);
    end
  end

endmodule
`default_nettype wire

### rtl/vdsu_iter.sv
// Shared digit-serial unit: integer square root (2 radicand bits per cycle) or
// restoring division (1 bit per cycle) on one subtract/compare. Uses vdsu_pkg.
`default_nettype none
module vdsu_iter import vdsu_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  iter_req_t   req,
  output logic        busy,
  output logic        done,
  output logic [31:0] quot
);

  iter_op_t            op;
  logic [SHR_W-1:0]    shreg;
  logic [64:0]         rem;
  logic [DEN_W-1:0]    den;
  logic [STEP_W-1:0]   cnt;
  logic [65:0]         opa, opb, dif;
  logic                ge;

  always_comb begin
    if (op == OP_SQRT) begin
      opa = {rem[63:0], shreg[SHR_W-1 -: 2]};
      opb = {32'd0, quot, 2'b01};
    end else begin
      opa = {rem, shreg[SHR_W-1]};
      opb = {2'b00, den};
    end
    ge  = (opa >= opb);
    dif = opa - opb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op    <= req.op;
      shreg <= req.operand;
      den   <= req.divisor;
      rem   <= '0;
      quot  <= '0;
    end else if (busy) begin
      rem   <= ge ? dif[64:0] : opa[64:0];
      quot  <= {quot[30:0], ge};
      shreg <= (op == OP_SQRT) ? {shreg[SHR_W-3:0], 2'b00} : {shreg[SHR_W-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire
